/* rtl/drpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpr_pkg: shared constants, types and helpers of the paged ROM translator
// Widths of the page table, the frame pool and the item fields.
// ----------------------------------------------------------------------------
package drpr_pkg;

    localparam int PAGE_BITS   = 14;
    localparam int MAX_PAGES   = 256;
    localparam int MAX_FRAMES  = 64;
    localparam int PAGE_W      = $clog2(MAX_PAGES);
    localparam int FRAME_W     = $clog2(MAX_FRAMES);
    localparam int ADDR_W      = 22;
    localparam int RAND_W      = 20;
    localparam int RF_W        = 7;
    localparam int TP_W        = 9;
    localparam int CHUNK_W     = 8;
    localparam int NUM_CHUNKS  = MAX_PAGES / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
    localparam int POS_W       = $clog2(CHUNK_W);

    localparam logic [RF_W-1:0] RF_RESET = 7'd64;
    localparam logic [TP_W-1:0] TP_RESET = 9'd256;

    // configuration register indexes
    localparam logic REG_RESIDENT_FRAMES = 1'b0;
    localparam logic REG_TOTAL_PAGES     = 1'b1;

    typedef struct packed {
        logic                rd_en;
        logic [PAGE_W-1:0]   rd_page;
        logic                upd;
        logic [PAGE_W-1:0]   upd_page;
        logic [PAGE_W-1:0]   upd_victim;
        logic [FRAME_W-1:0]  upd_frame;
        logic                rebuild;
        logic [RF_W-1:0]     rebuild_eff;
    } tbl_cmd_t;

    // page count limit, saturated to 1..MAX_PAGES
    function automatic logic [TP_W-1:0] page_limit(input logic [TP_W-1:0] tp);
        logic [TP_W-1:0] pg;
        pg = tp;
        if (pg < 9'd1)
            pg = 9'd1;
        if (pg > TP_W'(MAX_PAGES))
            pg = TP_W'(MAX_PAGES);
        return pg;
    endfunction

    // resident page count: min of saturated frames and saturated pages
    function automatic logic [RF_W-1:0] eff_resident(input logic [RF_W-1:0] rf,
                                                      input logic [TP_W-1:0] tp);
        logic [RF_W-1:0] fr;
        logic [TP_W-1:0] pg;
        fr = rf;
        if (fr < 7'd2)
            fr = 7'd2;
        if (fr > RF_W'(MAX_FRAMES))
            fr = RF_W'(MAX_FRAMES);
        pg = page_limit(tp);
        if ({2'b00, fr} < pg)
            return fr;
        return pg[RF_W-1:0];
    endfunction

endpackage

/* rtl/drpr_mod_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpr_mod_unit: serial remainder unit
// Restoring remainder of a 20-bit value by a 6-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module drpr_mod_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [drpr_pkg::RAND_W-1:0]  dividend,
    input  logic [drpr_pkg::FRAME_W-1:0] divisor,
    output logic                         done,
    output logic [drpr_pkg::FRAME_W-1:0] remainder
);

    localparam int CNT_W = $clog2(drpr_pkg::RAND_W + 1);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [drpr_pkg::RAND_W-1:0]  dvd_reg, dvd_next;
    logic [drpr_pkg::FRAME_W-1:0] dsr_reg, dsr_next;
    logic [drpr_pkg::FRAME_W-1:0] rem_reg, rem_next;
    logic [drpr_pkg::FRAME_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[drpr_pkg::RAND_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // subtract when the partial remainder reaches the divisor
            if (trial >= {1'b0, dsr_reg})
                trial = trial - {1'b0, dsr_reg};
            rem_next = trial[drpr_pkg::FRAME_W-1:0];
            dvd_next = {dvd_reg[drpr_pkg::RAND_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(drpr_pkg::RAND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    // a zero divisor means a single resident page: pick the first
    assign remainder = (dsr_reg == '0) ? '0 : rem_reg;

endmodule

/* rtl/drpr_page_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpr_page_table: page residency flags and frame memory
// Resident flags in flip-flops, frames in a memory with registered read.
// Entries never written read back their identity frame.
// ----------------------------------------------------------------------------
module drpr_page_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  drpr_pkg::tbl_cmd_t              cmd,
    output logic [drpr_pkg::MAX_PAGES-1:0]  resident,
    output logic [drpr_pkg::FRAME_W-1:0]    rd_frame
);

    logic [drpr_pkg::MAX_PAGES-1:0] res_reg, res_next;
    logic [drpr_pkg::MAX_PAGES-1:0] valid_reg, valid_next;
    logic [drpr_pkg::FRAME_W-1:0]   frame_mem [drpr_pkg::MAX_PAGES];
    logic [drpr_pkg::FRAME_W-1:0]   rd_data_reg;
    logic                           rd_valid_reg;
    logic [drpr_pkg::PAGE_W-1:0]    rd_page_reg;

    always_comb
    begin
        res_next   = res_reg;
        valid_next = valid_reg;
        if (cmd.rebuild)
        begin
            for (int p = 0; p < drpr_pkg::MAX_PAGES; p++)
                res_next[p] = (p < int'(cmd.rebuild_eff));
            valid_next = '0;
        end
        else if (cmd.upd)
        begin
            res_next[cmd.upd_victim] = 1'b0;
            res_next[cmd.upd_page]   = 1'b1;
            valid_next[cmd.upd_page] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < drpr_pkg::MAX_PAGES; p++)
                res_reg[p] <= (p < drpr_pkg::MAX_FRAMES);
            valid_reg <= '0;
        end
        else
        begin
            res_reg   <= res_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
            frame_mem[cmd.upd_page] <= cmd.upd_frame;
        if (cmd.rd_en)
        begin
            rd_data_reg  <= frame_mem[cmd.rd_page];
            rd_valid_reg <= valid_reg[cmd.rd_page];
            rd_page_reg  <= cmd.rd_page;
        end
    end

    assign resident = res_reg;
    assign rd_frame = rd_valid_reg ? rd_data_reg : rd_page_reg[drpr_pkg::FRAME_W-1:0];

endmodule

/* rtl/demand_paged_rom_random_replace_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_paged_rom_random_replace_unit: paged ROM address translator
// Maps byte addresses onto page frames, evicting a random resident page.
// ----------------------------------------------------------------------------
// One item at a time. A hit or an out-of-range page goes from the lookup state
// straight to the output state. A miss first forms random mod (resident pages
// - 1) in the serial remainder unit, one bit a cycle, then scans the residency
// flags eight pages a cycle for the victim, then commits the new mapping. Input
// is taken again once the result sits in the output register; while that
// register is still full, the finished result waits and input stays blocked. A
// configuration write rebuilds the table in the same cycle.
module demand_paged_rom_random_replace_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] operation, [22:1] byte_address, [42:23] random_value
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] hit, [6:1] frame_index, [20:7] page_offset, [21] load_request,
    // [29:22] loaded_page, [37:30] evicted_page, [38] range_error
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOKUP = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    localparam int PW = drpr_pkg::PAGE_W;
    localparam int FW = drpr_pkg::FRAME_W;
    localparam int CW = drpr_pkg::CHUNK_W;
    localparam int KW = drpr_pkg::CHUNK_IDX_W;
    localparam int OW = drpr_pkg::PAGE_BITS;

    function automatic logic [drpr_pkg::POS_W:0] count8(input logic [CW-1:0] b);
        logic [drpr_pkg::POS_W:0] c;
        c = '0;
        for (int i = 0; i < CW; i++)
            c = c + (drpr_pkg::POS_W + 1)'(b[i]);
        return c;
    endfunction

    // position of the (n+1)th set bit
    function automatic logic [drpr_pkg::POS_W-1:0] select8(input logic [CW-1:0] b,
                                                           input logic [drpr_pkg::POS_W-1:0] n);
        logic [drpr_pkg::POS_W:0]   k;
        logic [drpr_pkg::POS_W-1:0] pos;
        k   = '0;
        pos = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (b[i])
            begin
                if (k == {1'b0, n})
                    pos = drpr_pkg::POS_W'(i);
                k = k + (drpr_pkg::POS_W + 1)'(1);
            end
        end
        return pos;
    endfunction

    logic [2:0]                 state_reg, state_next;
    logic [drpr_pkg::RF_W-1:0]  rf_reg, rf_next;
    logic [drpr_pkg::TP_W-1:0]  tp_reg, tp_next;
    logic                       out_valid_reg, out_valid_next;

    logic [PW-1:0]              page_reg, page_next;
    logic [OW-1:0]              offset_reg, offset_next;
    logic [FW-1:0]              n_reg, n_next;
    logic [KW-1:0]              chunk_reg, chunk_next;
    logic [PW-1:0]              victim_reg, victim_next;
    logic [39:0]                res_reg, res_next;
    logic [39:0]                out_data_reg, out_data_next;

    drpr_pkg::tbl_cmd_t             tbl_cmd;
    logic [drpr_pkg::MAX_PAGES-1:0] resident;
    logic [FW-1:0]                  rd_frame;
    logic                           div_done;
    logic [FW-1:0]                  div_rem;

    logic                       accept;
    logic [drpr_pkg::ADDR_W-1:0] in_addr;
    logic [drpr_pkg::RF_W-1:0]  eff;
    logic [drpr_pkg::RF_W-1:0]  eff_m1;
    logic [drpr_pkg::RF_W-1:0]  cfg_rf;
    logic [drpr_pkg::TP_W-1:0]  cfg_tp;
    logic [CW-1:0]              chunk_bits;
    logic [drpr_pkg::POS_W:0]   chunk_cnt;
    logic [drpr_pkg::POS_W-1:0] chunk_pos;
    logic                       slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_addr   = s_tdata[22:1] ^ {{(drpr_pkg::ADDR_W-1){1'b0}}, ~s_tdata[0]};
    assign eff       = drpr_pkg::eff_resident(rf_reg, tp_reg);
    assign eff_m1    = eff - drpr_pkg::RF_W'(1);
    assign slot_free = !out_valid_reg || m_tready;

    assign cfg_rf = (cfg_index == drpr_pkg::REG_RESIDENT_FRAMES) ? cfg_data[6:0] : rf_reg;
    assign cfg_tp = (cfg_index == drpr_pkg::REG_TOTAL_PAGES) ? cfg_data : tp_reg;

    // page 0 is never a victim
    assign chunk_bits = resident[{chunk_reg, 3'b000} +: CW]
                        & ~((chunk_reg == '0) ? CW'(1) : CW'(0));
    assign chunk_cnt  = count8(chunk_bits);
    assign chunk_pos  = select8(chunk_bits, n_reg[drpr_pkg::POS_W-1:0]);

    drpr_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (s_tdata[42:23]),
        .divisor   (eff_m1[FW-1:0]),
        .done      (div_done),
        .remainder (div_rem)
    );

    drpr_page_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (tbl_cmd),
        .resident (resident),
        .rd_frame (rd_frame)
    );

    always_comb
    begin
        state_next     = state_reg;
        rf_next        = rf_reg;
        tp_next        = tp_reg;
        out_valid_next = out_valid_reg;
        page_next      = page_reg;
        offset_next    = offset_reg;
        n_next         = n_reg;
        chunk_next     = chunk_reg;
        victim_next    = victim_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;

        tbl_cmd             = '0;
        tbl_cmd.rebuild     = cfg_we;
        tbl_cmd.rebuild_eff = drpr_pkg::eff_resident(cfg_rf, cfg_tp);
        tbl_cmd.upd_page    = page_reg;
        tbl_cmd.upd_victim  = victim_reg;
        tbl_cmd.upd_frame   = rd_frame;

        if (cfg_we)
        begin
            rf_next = cfg_rf;
            tp_next = cfg_tp;
        end

        if (m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    page_next       = in_addr[drpr_pkg::ADDR_W-1:OW];
                    offset_next     = in_addr[OW-1:0];
                    tbl_cmd.rd_en   = 1'b1;
                    tbl_cmd.rd_page = in_addr[drpr_pkg::ADDR_W-1:OW];
                    state_next      = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                res_next = {19'd0, offset_reg, 7'd0};
                if ({1'b0, page_reg} >= drpr_pkg::page_limit(tp_reg))
                begin
                    res_next[38] = 1'b1;
                    state_next   = ST_OUT;
                end
                else if (resident[page_reg])
                begin
                    res_next[0]   = 1'b1;
                    res_next[6:1] = rd_frame;
                    state_next    = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    n_next     = div_rem;
                    chunk_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ({{(FW-drpr_pkg::POS_W-1){1'b0}}, chunk_cnt} > n_reg)
                begin
                    victim_next     = {chunk_reg, chunk_pos};
                    tbl_cmd.rd_en   = 1'b1;
                    tbl_cmd.rd_page = {chunk_reg, chunk_pos};
                    state_next      = ST_COMMIT;
                end
                else
                begin
                    n_next     = n_reg - {{(FW-drpr_pkg::POS_W-1){1'b0}}, chunk_cnt};
                    chunk_next = chunk_reg + KW'(1);
                    // no victim anywhere: miss without load, table kept
                    if (chunk_reg == KW'(drpr_pkg::NUM_CHUNKS - 1))
                        state_next = ST_OUT;
                end
            end
            ST_COMMIT:
            begin
                tbl_cmd.upd    = 1'b1;
                res_next[6:1]  = rd_frame;
                res_next[21]   = 1'b1;
                res_next[29:22] = page_reg;
                res_next[37:30] = victim_reg;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                // hold the result until the output register frees up
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rf_reg        <= drpr_pkg::RF_RESET;
            tp_reg        <= drpr_pkg::TP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rf_reg        <= rf_next;
            tp_reg        <= tp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg     <= page_next;
        offset_reg   <= offset_next;
        n_reg        <= n_next;
        chunk_reg    <= chunk_next;
        victim_reg   <= victim_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_victim_resident: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_cmd.upd |-> (victim_reg != '0) && resident[victim_reg] && !resident[page_reg])
        else $error("evicted page is not a resident page other than page 0");

    a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !tbl_cmd.rebuild |=> $countones(resident) == $past($countones(resident)))
        else $error("resident page count changed without a rebuild");

    a_scan_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> div_done)
        else $error("victim scan started before the remainder was ready");

    a_hit_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[21]) && !(m_tdata[38] && (m_tdata[0] || m_tdata[21])))
        else $error("result flags hit, load and range error conflict");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the paged ROM address translator
// Streams byte reads into the unit under bursty input and a stalling output,
// mirrors the page table in a local predictor, and compares every result
// field by field. Walks several frame/page settings, saturated ones included.
// ----------------------------------------------------------------------------
module testbench;

    import drpr_pkg::*;

    localparam logic OP_SWAPPED = 1'b0;  // byte read with address bit 0 flipped
    localparam logic OP_PLAIN   = 1'b1;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned DRAIN_CYCLES = 64;

    // packed so that the last field sits in the lowest bits
    typedef struct packed {
        logic [RAND_W-1:0] rnd;
        logic [ADDR_W-1:0] addr;
        logic              op;
    } rom_read_t;

    typedef struct packed {
        logic                 range_error;
        logic [PAGE_W-1:0]    evicted_page;
        logic [PAGE_W-1:0]    loaded_page;
        logic                 load_request;
        logic [PAGE_BITS-1:0] page_offset;
        logic [FRAME_W-1:0]   frame_index;
        logic                 hit;
    } translation_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = REG_RESIDENT_FRAMES;
    logic [8:0]  cfg_data  = '0;

    demand_paged_rom_random_replace_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rom_read_t    queued_reads[$];
    translation_t pending_translations[$];

    // predictor state: [6] resident, [5:0] frame
    logic [6:0]      page_map [MAX_PAGES];
    logic [RF_W-1:0] frames_reg;
    logic [TP_W-1:0] pages_reg;

    int unsigned cycle_count     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    int unsigned hits_seen       = 0;
    int unsigned loads_seen      = 0;
    int unsigned range_errs_seen = 0;
    int unsigned settings_used   = 1;

    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int unsigned page_count_limit();
        int unsigned pg;
        pg = pages_reg;
        if (pg < 1)
            pg = 1;
        if (pg > MAX_PAGES)
            pg = MAX_PAGES;
        return pg;
    endfunction

    function automatic int unsigned resident_count();
        int unsigned fr;
        int unsigned pg;
        fr = frames_reg;
        if (fr < 2)
            fr = 2;
        if (fr > MAX_FRAMES)
            fr = MAX_FRAMES;
        pg = page_count_limit();
        return (fr < pg) ? fr : pg;
    endfunction

    function automatic void restore_identity_map();
        int unsigned n;
        n = resident_count();
        for (int unsigned p = 0; p < MAX_PAGES; p++)
            page_map[p] = (p < n) ? {1'b1, FRAME_W'(p)} : 7'd0;
    endfunction

    function automatic translation_t translate_read(input rom_read_t rd);
        translation_t      t;
        logic [ADDR_W-1:0] a;
        int unsigned       page;
        int unsigned       skip;
        int unsigned       victim;
        int unsigned       p;
        bit                found;
        a = rd.addr;
        if (rd.op == OP_SWAPPED)
            a[0] = ~a[0];
        page = a >> PAGE_BITS;
        t = '0;
        t.page_offset = a[PAGE_BITS-1:0];
        if (page >= page_count_limit())
        begin
            t.range_error = 1'b1;
            return t;
        end
        if (page_map[page][6])
        begin
            t.hit = 1'b1;
            t.frame_index = page_map[page][5:0];
            return t;
        end
        skip = (resident_count() > 1) ? rd.rnd % (resident_count() - 1) : 0;
        found = 1'b0;
        victim = 0;
        // page 0 is pinned, so the scan starts at page 1
        for (p = 1; p < MAX_PAGES && !found; p++)
        begin
            if (page_map[p][6])
            begin
                if (skip == 0)
                begin
                    victim = p;
                    found = 1'b1;
                end
                else
                    skip--;
            end
        end
        if (!found)
            return t;
        page_map[page] = {1'b1, page_map[victim][5:0]};
        page_map[victim] = 7'd0;
        t.frame_index = page_map[page][5:0];
        t.load_request = 1'b1;
        t.loaded_page = PAGE_W'(page);
        t.evicted_page = PAGE_W'(victim);
        return t;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // predict on accepted input, check on accepted output
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        translation_t got;
        translation_t want;
        if (!rst_n)
        begin
            frames_reg = RF_RESET;
            pages_reg = TP_RESET;
            restore_identity_map();
            pending_translations.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_RESIDENT_FRAMES)
                    frames_reg = cfg_data[RF_W-1:0];
                else
                    pages_reg = cfg_data;
                restore_identity_map();
            end
            if (s_tvalid && s_tready)
                pending_translations.push_back(translate_read(rom_read_t'(s_tdata[42:0])));
            if (m_tvalid && m_tready)
            begin
                got = translation_t'(m_tdata[38:0]);
                if (pending_translations.size() == 0)
                begin
                    $error("result with no read outstanding: %h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_translations.pop_front();
                    check_field("hit", want.hit, got.hit);
                    check_field("frame_index", want.frame_index, got.frame_index);
                    check_field("page_offset", want.page_offset, got.page_offset);
                    check_field("load_request", want.load_request, got.load_request);
                    check_field("loaded_page", want.loaded_page, got.loaded_page);
                    check_field("evicted_page", want.evicted_page, got.evicted_page);
                    check_field("range_error", want.range_error, got.range_error);
                    results_checked++;
                    hits_seen += want.hit;
                    loads_seen += want.load_request;
                    range_errs_seen += want.range_error;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0 || queued_reads.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                s_tdata <= {5'b0, queued_reads.pop_front()};
                s_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output stall: switch between stall patterns every so often
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_mode = 0;
            mode_left = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (cycle_count % 16 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_read(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [RAND_W-1:0] rnd);
        rom_read_t rd;
        rd.op = op;
        rd.addr = addr;
        rd.rnd = rnd;
        queued_reads.push_back(rd);
    endtask

    // limit is the page count in force; pages past it are drawn now and then
    task automatic queue_random_reads(input int unsigned count, input int unsigned limit);
        int unsigned recent [4];
        int unsigned page;
        rom_read_t   rd;
        recent = '{default: 0};
        for (int unsigned k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: page = recent[$urandom_range(0, 3)];
                3:       page = $urandom_range(0, MAX_PAGES - 1);
                default: page = $urandom_range(0, limit - 1);
            endcase
            recent[k % 4] = page;
            rd.op = 1'($urandom_range(0, 1));
            rd.addr = {8'(page), 14'($urandom)};
            case ($urandom_range(0, 7))
                0:       rd.rnd = '0;
                1:       rd.rnd = '1;
                default: rd.rnd = 20'($urandom);
            endcase
            queued_reads.push_back(rd);
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (queued_reads.size() != 0 || s_tvalid || pending_translations.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_pages(input logic [8:0] frames, input logic [8:0] pages,
                             input int unsigned count, input int unsigned limit);
        wait_idle();
        write_reg(REG_RESIDENT_FRAMES, frames);
        write_reg(REG_TOTAL_PAGES, pages);
        settings_used++;
        queue_random_reads(count, limit);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: 64 frames over 256 pages
        push_read(OP_PLAIN,   22'h000000, 20'h00000);
        push_read(OP_SWAPPED, 22'h000000, 20'h00000);
        push_read(OP_PLAIN,   22'h3FFFFF, 20'hFFFFF);
        push_read(OP_SWAPPED, 22'h3FFFFF, 20'h00000);
        push_read(OP_PLAIN,   {8'd63, 14'h3FFF}, 20'h00000);
        push_read(OP_PLAIN,   {8'd64, 14'h0000}, 20'h00000);
        push_read(OP_SWAPPED, {8'd64, 14'h2AAA}, 20'h55555);
        push_read(OP_PLAIN,   {8'd200, 14'h1555}, 20'd62);
        push_read(OP_PLAIN,   {8'd128, 14'h0000}, 20'd63);
        push_read(OP_PLAIN,   {8'd1, 14'h0001}, 20'hAAAAA);
        queue_random_reads(450, 256);

        // two frames: page 0 pinned, one frame shared by everything else
        wait_idle();
        write_reg(REG_RESIDENT_FRAMES, 9'd2);
        settings_used++;
        push_read(OP_PLAIN,   {8'd1, 14'h0000}, 20'h00000);
        push_read(OP_PLAIN,   {8'd2, 14'h0010}, 20'hFFFFF);
        push_read(OP_SWAPPED, {8'd1, 14'h3FFF}, 20'h00001);
        push_read(OP_PLAIN,   {8'd0, 14'h3FFF}, 20'h00000);
        queue_random_reads(200, 256);

        // page count zero saturates to a single page
        wait_idle();
        write_reg(REG_TOTAL_PAGES, 9'd0);
        settings_used++;
        push_read(OP_PLAIN,   22'h000000, 20'h00000);
        push_read(OP_SWAPPED, {8'd1, 14'h0000}, 20'h00000);
        push_read(OP_PLAIN,   22'h3FFFFF, 20'hFFFFF);
        queue_random_reads(40, 1);

        set_pages(9'd0,     9'd20,  150, 20);   // frames saturate up to 2
        set_pages(9'd127,   9'd100, 250, 100);  // frames saturate down to 64
        set_pages(9'h1C2,   9'd511, 250, 256);  // upper bits dropped, pages saturate
        set_pages(9'd33,    9'd257, 250, 256);
        set_pages(9'd64,    9'd64,  60,  64);   // every page resident
        set_pages(9'd9,     9'd12,  100, 12);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d reads checked over %0d page settings in %0d cycles",
                 results_checked, settings_used, cycle_count);
        $display("%0d hits, %0d page loads, %0d out-of-range reads",
                 hits_seen, loads_seen, range_errs_seen);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
